### hw/rtl/srar_pkg.sv
// Shared types and constants for the serial register access responder.
// No dependencies; imported by srar_map and the core.
`default_nettype none

package srar_pkg;

    localparam int C_BYTE_W = 8;                 // one serial byte
    localparam int C_CNT_W  = 5;                 // frame byte counters
    localparam int C_SUM_W  = C_BYTE_W + 1;      // address plus length
    localparam int C_PADDR_W = 3;                // two 32-bit registers
    localparam int C_PDATA_W = 32;

    // configuration register indexes (paddr[2])
    localparam logic C_REG_RD_CODE = 1'b0;
    localparam logic C_REG_WR_CODE = 1'b1;

    localparam logic [C_BYTE_W-1:0] C_RD_CODE_RST = 8'h01;
    localparam logic [C_BYTE_W-1:0] C_WR_CODE_RST = 8'h02;

    // second byte of a write response
    localparam logic [C_BYTE_W-1:0] C_ACK_CODE  = 8'h00;
    localparam logic [C_BYTE_W-1:0] C_NACK_CODE = 8'hFF;

endpackage

`default_nettype wire

### hw/rtl/srar_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module srar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/srar_map.sv
// Register map: one RAM plus a valid bit per entry so reset reads as zero.
// Depends on srar_pkg and srar_ram.
`default_nettype none

module srar_map #(
    parameter int MAP_SIZE = 64,
    localparam int AW = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [AW-1:0]                 i_wr_addr,
    input  wire logic [srar_pkg::C_BYTE_W-1:0] i_wr_data,
    input  wire logic [AW-1:0]                 i_rd_addr,
    output logic      [srar_pkg::C_BYTE_W-1:0] o_rd_data
);
    import srar_pkg::*;

    logic [MAP_SIZE-1:0] r_valid;
    logic                r_rd_valid;
    logic [C_BYTE_W-1:0] ram_rdata;

    srar_ram #(
        .WIDTH (C_BYTE_W),
        .DEPTH (MAP_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wr_data),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
        r_rd_valid <= r_valid[i_rd_addr];
    end

    // entries never written since reset read as zero
    assign o_rd_data = r_rd_valid ? ram_rdata : '0;

endmodule

`default_nettype wire

### hw/rtl/serial_register_access_responder_core.sv
// Serial register access responder: frame parser, write buffer and map sequencer.
// Depends on srar_pkg, srar_ram and srar_map.
//
// Usage:
//   rx channel (i_rx_valid / o_rx_stall / i_rx_byte) takes one received byte per
//   item. Frames are command, address, length, then a checksum byte (read) or
//   length data bytes and a checksum byte (write). Checksums are XOR over the frame.
//   tx channel (o_tx_valid / i_tx_stall / o_tx_byte / o_last_of_frame) carries
//   response bytes; o_last_of_frame marks the closing checksum byte.
//   A good read checksum holds the rx side while the register map is streamed
//   out through its single read port, one byte a cycle while tx is not stalled;
//   the first response byte, the address, goes to the output register from the
//   address state. A good write checksum copies the buffer into the map one byte
//   a cycle, then sends the 3-byte ACK; a bad one sends the NACK. A stalled tx
//   holds the output register and the response states, but not the commit.
//   Reset returns the parser to the command phase, restores command codes 1 and
//   2 and marks every map entry as zero at once; no clearing pass is needed.
//   The user must write command codes over the APB port only while the block is
//   idle; the block itself does not enforce this.
`default_nettype none

module serial_register_access_responder_core #(
    parameter int MAP_SIZE    = 64,
    parameter int MAX_PAYLOAD = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // receive channel
    input  wire logic                           i_rx_valid,
    output logic                                o_rx_stall,
    input  wire logic [srar_pkg::C_BYTE_W-1:0]  i_rx_byte,
    // transmit channel
    output logic                                o_tx_valid,
    input  wire logic                           i_tx_stall,
    output logic      [srar_pkg::C_BYTE_W-1:0]  o_tx_byte,
    output logic                                o_last_of_frame,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [srar_pkg::C_PADDR_W-1:0] paddr,
    input  wire logic [srar_pkg::C_PDATA_W-1:0] pwdata,
    output logic      [srar_pkg::C_PDATA_W-1:0] prdata,
    output logic                                pready
);
    import srar_pkg::*;

    localparam int MAP_AW  = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
    localparam int WBUF_AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [C_SUM_W-1:0]  MAP_LIMIT = C_SUM_W'(MAP_SIZE);
    localparam logic [C_BYTE_W-1:0] PAY_LIMIT = C_BYTE_W'(MAX_PAYLOAD);

    // position inside the request frame
    typedef enum logic [2:0] {
        PH_CMD, PH_ADDR, PH_LEN, PH_RD_CHK, PH_WR_DATA, PH_WR_CHK, PH_DISCARD
    } t_phase;

    // sequencer: taking rx bytes, streaming a read, committing, answering a write
    typedef enum logic [3:0] {
        ST_RX, ST_RD_ADDR, ST_RD_LEN, ST_RD_DATA, ST_RD_SUM,
        ST_COMMIT, ST_ACK0, ST_ACK1, ST_ACK2
    } t_state;

    t_state              r_state,     n_state;
    t_phase              r_phase,     n_phase;
    logic [C_BYTE_W-1:0] r_cmd,       n_cmd;
    logic [C_BYTE_W-1:0] r_addr,      n_addr;
    logic [C_BYTE_W-1:0] r_len,       n_len;
    logic [C_CNT_W-1:0]  r_cnt,       n_cnt;
    logic [C_BYTE_W-1:0] r_xor,       n_xor;
    logic [C_CNT_W-1:0]  r_disc,      n_disc;
    logic [C_CNT_W-1:0]  r_idx,       n_idx;
    logic [C_BYTE_W-1:0] r_sum,       n_sum;
    logic                r_nack,      n_nack;
    logic                r_out_valid, n_out_valid;
    logic [C_BYTE_W-1:0] r_out_byte,  n_out_byte;
    logic                r_out_last,  n_out_last;
    logic [C_BYTE_W-1:0] r_rd_code;
    logic [C_BYTE_W-1:0] r_wr_code;

    logic                rx_acc;
    logic                tx_take;
    logic                out_free;
    logic                cfg_wr;
    logic                hdr_rd;
    logic                hdr_wr;
    logic [C_SUM_W-1:0]  hdr_end;
    logic                hdr_bad_range;
    logic                hdr_too_long;
    logic [C_CNT_W-1:0]  hdr_disc;
    logic [C_SUM_W-1:0]  frm_end;
    logic                rd_ok;
    logic                wbuf_we;
    logic [C_BYTE_W-1:0] wbuf_rdata;
    logic                map_we;
    logic [MAP_AW-1:0]   map_waddr;
    logic [MAP_AW-1:0]   map_raddr;
    logic [C_BYTE_W-1:0] map_rdata;

    // ---------------------------------------------------------------- config
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = {{(C_PDATA_W - C_BYTE_W){1'b0}},
                     (paddr[2] == C_REG_WR_CODE) ? r_wr_code : r_rd_code};

    // ---------------------------------------------------------------- handshakes
    assign o_rx_stall      = (r_state != ST_RX);
    assign rx_acc          = i_rx_valid && !o_rx_stall;
    assign tx_take         = r_out_valid && !i_tx_stall;
    assign out_free        = !r_out_valid || !i_tx_stall;
    assign o_tx_valid      = r_out_valid;
    assign o_tx_byte       = r_out_byte;
    assign o_last_of_frame = r_out_last;

    // ---------------------------------------------------------------- header check
    // Codes are compared once, when the length byte arrives; read wins a tie.
    assign hdr_rd        = (r_cmd == r_rd_code);
    assign hdr_wr        = !hdr_rd && (r_cmd == r_wr_code);
    assign hdr_end       = {1'b0, r_addr} + {1'b0, i_rx_byte};
    assign hdr_bad_range = ({1'b0, r_addr} >= MAP_LIMIT) || (hdr_end > MAP_LIMIT);
    assign hdr_too_long  = (i_rx_byte > PAY_LIMIT);

    // bytes to drop after a rejected header
    always_comb begin
        hdr_disc = '0;
        if (hdr_bad_range) begin
            if (hdr_rd) begin
                hdr_disc = C_CNT_W'(1);
            end else if (hdr_wr && !hdr_too_long) begin
                hdr_disc = C_CNT_W'(i_rx_byte) + C_CNT_W'(1);
            end
        end else if (hdr_too_long && hdr_rd) begin
            hdr_disc = C_CNT_W'(1);
        end
    end

    assign frm_end = {1'b0, r_addr} + {1'b0, r_len};
    assign rd_ok   = (i_rx_byte == r_xor) && (r_len <= PAY_LIMIT) && (frm_end <= MAP_LIMIT);

    // ---------------------------------------------------------------- storage
    // Read addresses follow the next index so the registered data always
    // matches the current index, also across tx stalls.
    assign map_raddr = MAP_AW'({1'b0, r_addr} + C_SUM_W'(n_idx));
    assign map_waddr = MAP_AW'({1'b0, r_addr} + C_SUM_W'(r_idx));

    srar_ram #(
        .WIDTH (C_BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_wbuf (
        .i_clk   (i_clk),
        .i_we    (wbuf_we),
        .i_waddr (r_cnt[WBUF_AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (n_idx[WBUF_AW-1:0]),
        .o_rdata (wbuf_rdata)
    );

    srar_map #(
        .MAP_SIZE (MAP_SIZE)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (map_we),
        .i_wr_addr (map_waddr),
        .i_wr_data (wbuf_rdata),
        .i_rd_addr (map_raddr),
        .o_rd_data (map_rdata)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_xor       = r_xor;
        n_disc      = r_disc;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_nack      = r_nack;
        n_out_valid = r_out_valid && !tx_take;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        wbuf_we     = 1'b0;
        map_we      = 1'b0;

        unique case (r_state)
            ST_RX: begin
                if (rx_acc) begin
                    unique case (r_phase)
                        PH_CMD: begin
                            n_cmd   = i_rx_byte;
                            n_phase = PH_ADDR;
                        end
                        PH_ADDR: begin
                            n_addr  = i_rx_byte;
                            n_phase = PH_LEN;
                        end
                        PH_LEN: begin
                            n_len  = i_rx_byte;
                            n_xor  = r_cmd ^ r_addr ^ i_rx_byte;
                            n_cnt  = '0;
                            n_disc = hdr_disc;
                            if (hdr_disc != '0) begin
                                n_phase = PH_DISCARD;
                            end else if (hdr_bad_range || hdr_too_long) begin
                                n_phase = PH_CMD;
                            end else if (hdr_rd) begin
                                n_phase = PH_RD_CHK;
                            end else if (hdr_wr) begin
                                n_phase = (i_rx_byte != '0) ? PH_WR_DATA : PH_WR_CHK;
                            end else begin
                                // unknown command: drop the header only
                                n_phase = PH_CMD;
                            end
                        end
                        PH_RD_CHK: begin
                            n_phase = PH_CMD;
                            if (rd_ok) begin
                                n_idx   = '0;
                                n_state = ST_RD_ADDR;
                            end
                        end
                        PH_WR_DATA: begin
                            wbuf_we = 1'b1;
                            n_xor   = r_xor ^ i_rx_byte;
                            n_cnt   = r_cnt + C_CNT_W'(1);
                            if (C_BYTE_W'(n_cnt) >= r_len) begin
                                n_phase = PH_WR_CHK;
                            end
                        end
                        PH_WR_CHK: begin
                            n_phase = PH_CMD;
                            n_idx   = '0;
                            if (i_rx_byte == r_xor) begin
                                n_nack  = 1'b0;
                                n_state = (r_len != '0) ? ST_COMMIT : ST_ACK0;
                            end else begin
                                n_nack  = 1'b1;
                                n_state = ST_ACK0;
                            end
                        end
                        PH_DISCARD: begin
                            if (r_disc != '0) begin
                                n_disc = r_disc - C_CNT_W'(1);
                            end
                            if (n_disc == '0) begin
                                n_phase = PH_CMD;
                            end
                        end
                        default: begin
                            n_phase = PH_CMD;
                        end
                    endcase
                end
            end
            ST_RD_ADDR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_addr;
                    n_out_last  = 1'b0;
                    n_sum       = r_addr;
                    n_state     = ST_RD_LEN;
                end
            end
            ST_RD_LEN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_len;
                    n_out_last  = 1'b0;
                    n_sum       = r_sum ^ r_len;
                    n_state     = (r_len != '0) ? ST_RD_DATA : ST_RD_SUM;
                end
            end
            ST_RD_DATA: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = map_rdata;
                    n_out_last  = 1'b0;
                    n_sum       = r_sum ^ map_rdata;
                    n_idx       = r_idx + C_CNT_W'(1);
                    if (C_BYTE_W'(n_idx) == r_len) begin
                        n_state = ST_RD_SUM;
                    end
                end
            end
            ST_RD_SUM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_sum;
                    n_out_last  = 1'b1;
                    n_state     = ST_RX;
                end
            end
            ST_COMMIT: begin
                // buffer byte for r_idx is on the RAM output now
                map_we = 1'b1;
                n_idx  = r_idx + C_CNT_W'(1);
                if (C_BYTE_W'(n_idx) == r_len) begin
                    n_state = ST_ACK0;
                end
            end
            ST_ACK0: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_addr;
                    n_out_last  = 1'b0;
                    n_state     = ST_ACK1;
                end
            end
            ST_ACK1: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_nack ? C_NACK_CODE : C_ACK_CODE;
                    n_out_last  = 1'b0;
                    n_state     = ST_ACK2;
                end
            end
            ST_ACK2: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_addr ^ (r_nack ? C_NACK_CODE : C_ACK_CODE);
                    n_out_last  = 1'b1;
                    n_state     = ST_RX;
                end
            end
            default: begin
                n_state = ST_RX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RX;
            r_phase     <= PH_CMD;
            r_cmd       <= '0;
            r_addr      <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_xor       <= '0;
            r_disc      <= '0;
            r_idx       <= '0;
            r_nack      <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_code   <= C_RD_CODE_RST;
            r_wr_code   <= C_WR_CODE_RST;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cmd       <= n_cmd;
            r_addr      <= n_addr;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_xor       <= n_xor;
            r_disc      <= n_disc;
            r_idx       <= n_idx;
            r_nack      <= n_nack;
            r_out_valid <= n_out_valid;
            if (cfg_wr && paddr[2] == C_REG_RD_CODE) begin
                r_rd_code <= pwdata[C_BYTE_W-1:0];
            end
            if (cfg_wr && paddr[2] == C_REG_WR_CODE) begin
                r_wr_code <= pwdata[C_BYTE_W-1:0];
            end
        end
        r_sum      <= n_sum;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    // ---------------------------------------------------------------- checks
    // a pending closing byte only coexists with the start of the next answer
    a_last_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |->
        (r_state == ST_RX || r_state == ST_RD_ADDR ||
         r_state == ST_COMMIT || r_state == ST_ACK0))
        else $error("closing byte pending while a response is mid-stream");

    a_commit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) |-> (C_BYTE_W'(r_idx) < r_len))
        else $error("commit index past write length");

    a_stream_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD_DATA) |-> (C_BYTE_W'(r_idx) < r_len && r_len <= PAY_LIMIT))
        else $error("read stream index past length");

    a_discard_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DISCARD) |-> (r_disc != '0))
        else $error("discard phase with nothing left to drop");

endmodule

`default_nettype wire
